[hw/rtl/irlt_pkg.sv]
// ----------------------------------------------------------------------------
// irlt_pkg
// Shared types and constants of the IR line tokenizer: token record, the
// per-byte token bundle passed from the lexer to the emitter, queue sizing.
// ----------------------------------------------------------------------------
package irlt_pkg;

	// Column counter width; columns and lengths saturate at the smaller of
	// 2^COLUMN_BITS-1 and the 16-bit field maximum.
	localparam int COLUMN_BITS = 16;
	localparam int COL_W       = 16;
	localparam int COL_LIMIT_I = (COLUMN_BITS >= COL_W) ? ((2 ** COL_W) - 1)
	                                                    : ((2 ** COLUMN_BITS) - 1);
	localparam logic [COL_W-1:0] COL_LIMIT = COL_LIMIT_I[COL_W-1:0];

	localparam int KIND_W = 5;

	// One byte can cause at most four tokens.
	localparam int MAX_TOKS = 4;
	localparam int TIDX_W   = $clog2(MAX_TOKS);
	localparam int TCNT_W   = $clog2(MAX_TOKS + 1);

	// Bundle queue between lexer and emitter.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [COL_W-1:0]  len;
		logic [COL_W-1:0]  start;
		logic [KIND_W-1:0] kind;
	} tok_t;

	typedef struct packed {
		tok_t [MAX_TOKS-1:0] toks;
		logic [TCNT_W-1:0]   count;
	} bundle_t;

	function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] x);
		return (x < COL_LIMIT) ? (x + COL_W'(1)) : COL_LIMIT;
	endfunction

endpackage

[hw/rtl/irlt_front.sv]
// ----------------------------------------------------------------------------
// irlt_front
// Lexer front end: classifies each accepted byte against the lexer state and
// collects the tokens it causes into one bundle for the queue.
// ----------------------------------------------------------------------------
module irlt_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               ch,
	input  logic                     has_char,
	input  logic                     line_end,
	output logic                     push,
	output irlt_pkg::bundle_t        push_data
);

	localparam logic [3:0] M_IDLE     = 4'd0;
	localparam logic [3:0] M_IDENT    = 4'd1;
	localparam logic [3:0] M_REG      = 4'd2;
	localparam logic [3:0] M_GLOBAL   = 4'd3;
	localparam logic [3:0] M_MANT     = 4'd4;
	localparam logic [3:0] M_EXP0     = 4'd5;
	localparam logic [3:0] M_EXP1     = 4'd6;
	localparam logic [3:0] M_WORD     = 4'd7;
	localparam logic [3:0] M_MINUS    = 4'd8;
	localparam logic [3:0] M_MINUS_I  = 4'd9;
	localparam logic [3:0] M_MINUS_IN = 4'd10;
	localparam logic [3:0] M_MINUS_N  = 4'd11;
	localparam logic [3:0] M_MINUS_NA = 4'd12;

	localparam logic [4:0] K_END      = 5'd0;
	localparam logic [4:0] K_IDENT    = 5'd1;
	localparam logic [4:0] K_REG      = 5'd2;
	localparam logic [4:0] K_GLOBAL   = 5'd3;
	localparam logic [4:0] K_NUMBER   = 5'd4;
	localparam logic [4:0] K_ARROW    = 5'd5;
	localparam logic [4:0] K_LPAREN   = 5'd6;
	localparam logic [4:0] K_RPAREN   = 5'd7;
	localparam logic [4:0] K_LBRACKET = 5'd8;
	localparam logic [4:0] K_RBRACKET = 5'd9;
	localparam logic [4:0] K_LBRACE   = 5'd10;
	localparam logic [4:0] K_RBRACE   = 5'd11;
	localparam logic [4:0] K_COMMA    = 5'd12;
	localparam logic [4:0] K_COLON    = 5'd13;
	localparam logic [4:0] K_QUESTION = 5'd14;
	localparam logic [4:0] K_EQUALS   = 5'd15;
	localparam logic [4:0] K_UNKNOWN  = 5'd16;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LO_E    = 8'h65;
	localparam logic [7:0] CH_UP_E    = 8'h45;
	localparam logic [7:0] CH_LO_I    = 8'h69;
	localparam logic [7:0] CH_LO_N    = 8'h6E;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	localparam logic [irlt_pkg::COL_W-1:0] COL_ONE = irlt_pkg::COL_W'(1);

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_body(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h5B:   k = K_LBRACKET;
			8'h5D:   k = K_RBRACKET;
			8'h7B:   k = K_LBRACE;
			8'h7D:   k = K_RBRACE;
			8'h2C:   k = K_COMMA;
			8'h3A:   k = K_COLON;
			8'h3F:   k = K_QUESTION;
			8'h3D:   k = K_EQUALS;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] mode_kind(input logic [3:0] m);
		logic [4:0] k;
		unique case (m)
			M_IDENT:  k = K_IDENT;
			M_REG:    k = K_REG;
			M_GLOBAL: k = K_GLOBAL;
			default:  k = K_NUMBER;
		endcase
		return k;
	endfunction

	// Append one token to a bundle; drop it if the bundle is already full.
	function automatic irlt_pkg::bundle_t add_tok(
		input irlt_pkg::bundle_t               b,
		input logic [4:0]                      kind,
		input logic [irlt_pkg::COL_W-1:0]      start,
		input logic [irlt_pkg::COL_W-1:0]      len
	);
		irlt_pkg::bundle_t r;
		r = b;
		if (b.count < irlt_pkg::TCNT_W'(irlt_pkg::MAX_TOKS)) begin
			r.toks[b.count[irlt_pkg::TIDX_W-1:0]].kind  = kind;
			r.toks[b.count[irlt_pkg::TIDX_W-1:0]].start = start;
			r.toks[b.count[irlt_pkg::TIDX_W-1:0]].len   = len;
			r.count = b.count + irlt_pkg::TCNT_W'(1);
		end
		return r;
	endfunction

	logic [3:0]                   mode_q;
	logic [irlt_pkg::COL_W-1:0]   col_q;
	logic [irlt_pkg::COL_W-1:0]   start_q;
	logic [irlt_pkg::COL_W-1:0]   len_q;

	logic [3:0]                   m;
	logic [irlt_pkg::COL_W-1:0]   col;
	logic [irlt_pkg::COL_W-1:0]   ts;
	logic [irlt_pkg::COL_W-1:0]   tl;
	logic                         split_now;
	logic                         startc;
	irlt_pkg::bundle_t            b;

	always_comb begin
		m      = (mode_q > M_MINUS_NA) ? M_IDLE : mode_q;
		col    = col_q;
		ts     = start_q;
		tl     = len_q;
		b      = '0;
		startc = 1'b0;

		split_now = ((m == M_MINUS_I)  && (ch != CH_LO_N)) ||
		            ((m == M_MINUS_IN) && (ch != CH_LO_F)) ||
		            ((m == M_MINUS_N)  && (ch != CH_LO_A)) ||
		            ((m == M_MINUS_NA) && (ch != CH_LO_N));

		if (has_char) begin
			// Failed -inf/-nan prefix: give the minus, rest becomes an identifier.
			if (split_now) begin
				b  = add_tok(b, K_UNKNOWN, ts, COL_ONE);
				ts = irlt_pkg::sat_inc(ts);
				tl = (tl != '0) ? (tl - COL_ONE) : '0;
				m  = M_IDENT;
			end

			case (m)
				M_IDENT, M_REG, M_GLOBAL, M_WORD: begin
					if (is_body(ch)) begin
						tl = irlt_pkg::sat_inc(tl);
					end else begin
						b      = add_tok(b, mode_kind(m), ts, tl);
						startc = 1'b1;
					end
				end
				M_MANT: begin
					if (is_digit(ch) || (ch == CH_DOT)) begin
						tl = irlt_pkg::sat_inc(tl);
					end else if ((ch == CH_LO_E) || (ch == CH_UP_E)) begin
						tl = irlt_pkg::sat_inc(tl);
						m  = M_EXP0;
					end else begin
						b      = add_tok(b, mode_kind(m), ts, tl);
						startc = 1'b1;
					end
				end
				M_EXP0: begin
					if (is_digit(ch) || (ch == CH_PLUS) || (ch == CH_MINUS)) begin
						tl = irlt_pkg::sat_inc(tl);
						m  = M_EXP1;
					end else begin
						b      = add_tok(b, mode_kind(m), ts, tl);
						startc = 1'b1;
					end
				end
				M_EXP1: begin
					if (is_digit(ch)) begin
						tl = irlt_pkg::sat_inc(tl);
					end else begin
						b      = add_tok(b, mode_kind(m), ts, tl);
						startc = 1'b1;
					end
				end
				M_MINUS: begin
					if (is_digit(ch) || (ch == CH_DOT)) begin
						tl = irlt_pkg::sat_inc(tl);
						m  = M_MANT;
					end else if (ch == CH_LO_I) begin
						tl = irlt_pkg::sat_inc(tl);
						m  = M_MINUS_I;
					end else if (ch == CH_LO_N) begin
						tl = irlt_pkg::sat_inc(tl);
						m  = M_MINUS_N;
					end else if (ch == CH_GT) begin
						b = add_tok(b, K_ARROW, ts, irlt_pkg::COL_W'(2));
						m = M_IDLE;
					end else begin
						b      = add_tok(b, K_UNKNOWN, ts, COL_ONE);
						startc = 1'b1;
					end
				end
				// Only the matching byte reaches here; a mismatch was split above.
				M_MINUS_I: begin
					tl = irlt_pkg::sat_inc(tl);
					m  = M_MINUS_IN;
				end
				M_MINUS_N: begin
					tl = irlt_pkg::sat_inc(tl);
					m  = M_MINUS_NA;
				end
				M_MINUS_IN, M_MINUS_NA: begin
					tl = irlt_pkg::sat_inc(tl);
					m  = M_WORD;
				end
				default: startc = 1'b1;
			endcase

			if (startc) begin
				m = M_IDLE;
				if (is_space(ch)) begin
					m = M_IDLE;
				end else if (ch == CH_PERCENT) begin
					m  = M_REG;
					ts = col;
					tl = '0;
				end else if (ch == CH_AT) begin
					m  = M_GLOBAL;
					ts = col;
					tl = '0;
				end else if (is_alpha(ch) || (ch == CH_UNDER)) begin
					m  = M_IDENT;
					ts = col;
					tl = COL_ONE;
				end else if (is_digit(ch)) begin
					m  = M_MANT;
					ts = col;
					tl = COL_ONE;
				end else if (ch == CH_MINUS) begin
					m  = M_MINUS;
					ts = col;
					tl = COL_ONE;
				end else begin
					b = add_tok(b, punct_kind(ch), col, COL_ONE);
				end
			end

			col = irlt_pkg::sat_inc(col);
		end

		if (line_end) begin
			case (m)
				M_IDLE: ;
				M_MINUS: b = add_tok(b, K_UNKNOWN, ts, COL_ONE);
				M_MINUS_I, M_MINUS_IN, M_MINUS_N, M_MINUS_NA: begin
					b  = add_tok(b, K_UNKNOWN, ts, COL_ONE);
					ts = irlt_pkg::sat_inc(ts);
					tl = (tl != '0) ? (tl - COL_ONE) : '0;
					b  = add_tok(b, K_IDENT, ts, tl);
				end
				default: b = add_tok(b, mode_kind(m), ts, tl);
			endcase
			b   = add_tok(b, K_END, col, '0);
			m   = M_IDLE;
			col = COL_ONE;
			ts  = '0;
			tl  = '0;
		end
	end

	assign push      = accept && (b.count != '0);
	assign push_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			col_q   <= COL_ONE;
			start_q <= '0;
			len_q   <= '0;
		end else if (accept) begin
			mode_q  <= m;
			col_q   <= col;
			start_q <= ts;
			len_q   <= tl;
		end
	end

endmodule

[hw/rtl/irlt_queue.sv]
// ----------------------------------------------------------------------------
// irlt_queue
// Small register FIFO of token bundles between lexer and emitter.
// ----------------------------------------------------------------------------
module irlt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irlt_pkg::bundle_t push_data,
	input  logic              pop,
	output irlt_pkg::bundle_t head,
	output logic              empty,
	output logic              full
);

	irlt_pkg::bundle_t               mem_q [irlt_pkg::QDEPTH];
	logic [irlt_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [irlt_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [irlt_pkg::QCNT_W-1:0]     cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == irlt_pkg::QCNT_W'(irlt_pkg::QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + irlt_pkg::QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + irlt_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + irlt_pkg::QCNT_W'(push && !full)
			               - irlt_pkg::QCNT_W'(pop && !empty);
		end
	end

endmodule

[hw/rtl/irlt_back.sv]
// ----------------------------------------------------------------------------
// irlt_back
// Token emitter: walks the head bundle one token a cycle, unless out_ready stalls
// it, into the output register and marks the bundle's last token.
// ----------------------------------------------------------------------------
module irlt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  irlt_pkg::bundle_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output irlt_pkg::tok_t    out_tok,
	output logic              out_last
);

	logic [irlt_pkg::TIDX_W-1:0] idx_q;
	logic                        out_valid_q;
	irlt_pkg::tok_t              tok_q;
	logic                        last_q;
	logic                        take;
	logic                        last_tok;

	assign take     = !out_valid_q || out_ready;
	assign last_tok = ({1'b0, idx_q} + irlt_pkg::TCNT_W'(1)) == head.count;
	assign pop      = take && !empty && last_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			out_valid_q <= !empty;
			if (!empty) begin
				idx_q <= last_tok ? '0 : (idx_q + irlt_pkg::TIDX_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !empty) begin
			tok_q  <= head.toks[idx_q];
			last_q <= last_tok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

endmodule

[hw/rtl/ir_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// ir_line_tokenizer
// Lexes a text line, one byte per transfer, into kind/column/length tokens.
// ----------------------------------------------------------------------------
// Unless stalled, the block takes one byte per cycle on the s_ side and gives one token
// per cycle on the m_ side. Each input transfer is lexed in the cycle it is accepted
// and any tokens it causes, up to four, are written as one bundle into a four-entry
// queue; the emitter drains bundles one token a cycle, unless m_tready stalls it,
// through an output register, with tlast on the final token of each bundle. The
// earliest token passes the bundle queue and then the output register before it
// shows on m_tvalid. s_tready drops only while the bundle queue is full, so a run of
// bytes that each cause one token streams at one item per cycle while m_tready stays
// high, and a byte that causes several tokens gives them out one after another.
// Line end (s_tlast) flushes any open token, emits End at the column after the last
// byte and returns the column to one. A byte with s_tuser low is a bare item: with
// s_tlast high it only ends the line, otherwise it produces nothing.
module ir_line_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] has_char
	input  logic        s_tlast,   // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] start_column,
	                               // [36:21] text_length, [39:37] zero
	output logic        m_tlast    // last_of_run
);

	logic              accept;
	logic              push;
	irlt_pkg::bundle_t push_data;
	irlt_pkg::bundle_t head;
	logic              empty;
	logic              full;
	logic              pop;
	irlt_pkg::tok_t    out_tok;

	// Accept a byte whenever its bundle has a free queue slot.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	irlt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ch        (s_tdata),
		.has_char  (s_tuser),
		.line_end  (s_tlast),
		.push      (push),
		.push_data (push_data)
	);

	irlt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	irlt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (out_tok),
		.out_last  (m_tlast)
	);

	// Pack the token fields from the lowest bit up, pad to whole bytes.
	assign m_tdata = {3'b000, out_tok.len, out_tok.start, out_tok.kind};

endmodule

[dv/irlt_token_checker.sv]
// ----------------------------------------------------------------------------
// irlt_token_checker
// Watches both streams of the line tokenizer, predicts the tokens of every
// accepted byte and compares each token transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module irlt_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output int          tokens_checked,
	output logic [16:0] kinds_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		LX_IDLE, LX_IDENT, LX_REG, LX_GLOBAL, LX_MANT, LX_EXP0, LX_EXP1, LX_WORD,
		LX_MINUS, LX_MINUS_I, LX_MINUS_IN, LX_MINUS_N, LX_MINUS_NA
	} lex_mode_e;

	typedef enum logic [4:0] {
		TK_END, TK_IDENT, TK_REG, TK_GLOBAL, TK_NUMBER, TK_ARROW, TK_LPAREN,
		TK_RPAREN, TK_LBRACKET, TK_RBRACKET, TK_LBRACE, TK_RBRACE, TK_COMMA,
		TK_COLON, TK_QUESTION, TK_EQUALS, TK_UNKNOWN
	} tok_kind_e;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} token_exp_t;

	lex_mode_e   lx       = LX_IDLE;
	logic [15:0] col_next = 16'd1;
	logic [15:0] tok_col  = '0;
	logic [15:0] tok_len  = '0;
	token_exp_t  burst [irlt_pkg::MAX_TOKS];
	int          burst_n;
	token_exp_t  expected_tokens [$];

	initial begin
		errors         = 0;
		pending        = 0;
		tokens_checked = 0;
		kinds_seen     = '0;
	end

	function automatic logic [15:0] col_bump(logic [15:0] x);
		return (x < irlt_pkg::COL_LIMIT) ? x + 16'd1 : irlt_pkg::COL_LIMIT;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_head(logic [7:0] c);
		return is_letter(c) || c == "_";
	endfunction

	function automatic bit is_body(logic [7:0] c);
		return is_head(c) || is_digit(c) || c == ".";
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic tok_kind_e punct_kind(logic [7:0] c);
		case (c)
			"(":     return TK_LPAREN;
			")":     return TK_RPAREN;
			"[":     return TK_LBRACKET;
			"]":     return TK_RBRACKET;
			"{":     return TK_LBRACE;
			"}":     return TK_RBRACE;
			",":     return TK_COMMA;
			":":     return TK_COLON;
			"?":     return TK_QUESTION;
			"=":     return TK_EQUALS;
			default: return TK_UNKNOWN;
		endcase
	endfunction

	// Drop anything past the fourth token of one byte.
	function automatic void put_tok(tok_kind_e kind, logic [15:0] start, logic [15:0] len);
		if (burst_n < irlt_pkg::MAX_TOKS) begin
			burst[burst_n] = '{kind, start, len, 1'b0};
			burst_n++;
		end
	endfunction

	function automatic void mark(lex_mode_e m, logic [15:0] len);
		lx      = m;
		tok_col = col_next;
		tok_len = len;
	endfunction

	function automatic tok_kind_e open_kind();
		case (lx)
			LX_IDENT:  return TK_IDENT;
			LX_REG:    return TK_REG;
			LX_GLOBAL: return TK_GLOBAL;
			default:   return TK_NUMBER;
		endcase
	endfunction

	function automatic void grow(lex_mode_e m);
		lx      = m;
		tok_len = col_bump(tok_len);
	endfunction

	// First byte of a new token, seen from the idle state.
	function automatic void open_at(logic [7:0] c);
		lx = LX_IDLE;
		if (is_blank(c))
			return;
		if (c == "%")
			mark(LX_REG, 16'd0);
		else if (c == "@")
			mark(LX_GLOBAL, 16'd0);
		else if (is_head(c))
			mark(LX_IDENT, 16'd1);
		else if (is_digit(c))
			mark(LX_MANT, 16'd1);
		else if (c == "-")
			mark(LX_MINUS, 16'd1);
		else
			put_tok(punct_kind(c), col_next, 16'd1);
	endfunction

	function automatic void close_then(logic [7:0] c);
		put_tok(open_kind(), tok_col, tok_len);
		open_at(c);
	endfunction

	// A broken "-inf"/"-nan" prefix: give the minus alone, keep the rest as
	// an identifier one column later.
	function automatic void split_dash();
		put_tok(TK_UNKNOWN, tok_col, 16'd1);
		tok_col = col_bump(tok_col);
		tok_len = (tok_len > 0) ? tok_len - 16'd1 : 16'd0;
		lx      = LX_IDENT;
	endfunction

	function automatic void body_byte(logic [7:0] c);
		if (is_body(c))
			grow(lx);
		else
			close_then(c);
	endfunction

	function automatic void lex_char(logic [7:0] c);
		case (lx) inside
			LX_IDENT, LX_REG, LX_GLOBAL, LX_WORD: begin
				body_byte(c);
			end
			LX_MANT: begin
				if (is_digit(c) || c == ".")
					grow(LX_MANT);
				else if (c == "e" || c == "E")
					grow(LX_EXP0);
				else
					close_then(c);
			end
			LX_EXP0: begin
				if (is_digit(c) || c == "+" || c == "-")
					grow(LX_EXP1);
				else
					close_then(c);
			end
			LX_EXP1: begin
				if (is_digit(c))
					grow(LX_EXP1);
				else
					close_then(c);
			end
			LX_MINUS: begin
				if (is_digit(c) || c == ".") begin
					grow(LX_MANT);
				end else if (c == "i") begin
					grow(LX_MINUS_I);
				end else if (c == "n") begin
					grow(LX_MINUS_N);
				end else if (c == ">") begin
					put_tok(TK_ARROW, tok_col, 16'd2);
					lx = LX_IDLE;
				end else begin
					put_tok(TK_UNKNOWN, tok_col, 16'd1);
					open_at(c);
				end
			end
			LX_MINUS_I: begin
				if (c == "n") grow(LX_MINUS_IN);
				else begin split_dash(); body_byte(c); end
			end
			LX_MINUS_IN: begin
				if (c == "f") grow(LX_WORD);
				else begin split_dash(); body_byte(c); end
			end
			LX_MINUS_N: begin
				if (c == "a") grow(LX_MINUS_NA);
				else begin split_dash(); body_byte(c); end
			end
			LX_MINUS_NA: begin
				if (c == "n") grow(LX_WORD);
				else begin split_dash(); body_byte(c); end
			end
			default: begin
				open_at(c);
			end
		endcase
	endfunction

	// Close whatever token is still open when the line ends.
	function automatic void flush_line();
		case (lx) inside
			LX_IDLE: ;
			LX_MINUS: begin
				put_tok(TK_UNKNOWN, tok_col, 16'd1);
			end
			LX_MINUS_I, LX_MINUS_IN, LX_MINUS_N, LX_MINUS_NA: begin
				split_dash();
				put_tok(TK_IDENT, tok_col, tok_len);
			end
			default: begin
				put_tok(open_kind(), tok_col, tok_len);
			end
		endcase
		lx = LX_IDLE;
	endfunction

	function automatic void predict_transfer(logic [7:0] ch, logic has, logic last);
		burst_n = 0;
		if (has) begin
			lex_char(ch);
			col_next = col_bump(col_next);
		end
		if (last) begin
			flush_line();
			put_tok(TK_END, col_next, 16'd0);
			col_next = 16'd1;
			tok_col  = '0;
			tok_len  = '0;
		end
		if (burst_n > 0)
			burst[burst_n-1].last = 1'b1;
		for (int i = 0; i < burst_n; i++)
			expected_tokens = {expected_tokens, burst[i]};
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("MISMATCH token %0d %s: expected %0d, got %0d", tokens_checked, what,
			want, got);
		errors++;
	endtask

	task automatic check_token();
		token_exp_t want;
		if (m_tdata[4:0] <= TK_UNKNOWN)
			kinds_seen[m_tdata[4:0]] = 1'b1;
		if (expected_tokens.size() == 0) begin
			report_mismatch("arrived with none pending, kind", -1, m_tdata[4:0]);
		end else begin
			want = expected_tokens.pop_front();
			if (m_tdata[4:0] !== want.kind)
				report_mismatch("token_kind", want.kind, m_tdata[4:0]);
			if (m_tdata[20:5] !== want.start)
				report_mismatch("start_column", want.start, m_tdata[20:5]);
			if (m_tdata[36:21] !== want.len)
				report_mismatch("text_length", want.len, m_tdata[36:21]);
			if (m_tlast !== want.last)
				report_mismatch("last_of_run", want.last, m_tlast);
			if (m_tdata[39:37] !== 3'b000)
				report_mismatch("padding", 0, m_tdata[39:37]);
		end
		tokens_checked++;
	endtask

	// Predict on the input side first; no token can leave in the cycle its
	// byte arrives, so the order within one edge does not matter.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx       = LX_IDLE;
			col_next = 16'd1;
			tok_col  = '0;
			tok_len  = '0;
			expected_tokens.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_transfer(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready)
				check_token();
			pending <= expected_tokens.size();
		end
	end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the IR line tokenizer: directed lines, then random
// lines built from token fragments, with random gaps on the byte side and
// random stalls on the token side. The checker beside the block does all the
// comparing.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any transfer before the run is declared hung.
	localparam int STUCK_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 100;

	typedef struct {
		logic [7:0] ch;
		logic       has;
		logic       last;
	} lex_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	int          errors;
	int          pending;
	int          tokens_checked;
	logic [16:0] kinds_seen;

	// Set while both sides should run flat out.
	bit          calm = 1'b0;
	int          bytes_sent = 0;
	int          lines_sent = 0;
	int          stuck = 0;
	lex_byte_t   line_q [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ir_line_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	irlt_token_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.errors         (errors),
		.pending        (pending),
		.tokens_checked (tokens_checked),
		.kinds_seen     (kinds_seen)
	);

	// Watchdog: any transfer on either side clears the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck <= 0;
		end else if (stuck == STUCK_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", STUCK_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	// Token side: draw a stall per token, then hold tready until a transfer.
	initial begin
		int stall;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Present one byte after a random gap and hold it until it is taken.
	// tvalid is only lowered when a gap follows, so back-to-back bytes keep
	// it high with a single assignment per edge.
	task automatic send_byte(logic [7:0] ch, logic has, logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tuser  <= has;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (last)
			lines_sent++;
	endtask

	// Send a string; end the line on its last byte or with a bare line end.
	task automatic send_text(string text, bit end_on_last);
		for (int i = 0; i < text.len(); i++)
			send_byte(text[i], 1'b1, end_on_last && (i == text.len() - 1));
		if (!end_on_last)
			send_byte(8'h00, 1'b0, 1'b1);
	endtask

	// Hold the byte side idle until every predicted token has come out.
	// The first edge lets the checker count the byte just taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_body();
		case ($urandom_range(0, 3))
			0:       return pick_letter();
			1:       return pick_digit();
			2:       return "_";
			default: return ".";
		endcase
	endfunction

	function automatic logic [7:0] pick_punct();
		string marks;
		marks = "()[]{},:?=";
		return marks[$urandom_range(0, 9)];
	endfunction

	function automatic logic [7:0] pick_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? " " : 8'(8 + r);
	endfunction

	// Append one item to the line being built.
	function automatic void add_item(logic [7:0] c, logic has, logic last);
		lex_byte_t e;
		e.ch   = c;
		e.has  = has;
		e.last = last;
		line_q = {line_q, e};
	endfunction

	function automatic void add_char(logic [7:0] c);
		add_item(c, 1'b1, 1'b0);
	endfunction

	// One random token-shaped fragment, mostly well formed.
	function automatic void add_fragment();
		string word;
		int    n;
		case ($urandom_range(0, 11)) inside
			0: begin
				add_char(($urandom_range(0, 4) == 0) ? 8'("_") : pick_letter());
				repeat ($urandom_range(0, 5)) add_char(pick_body());
			end
			1, 2: begin
				add_char(($urandom_range(0, 1) == 1) ? 8'("%") : 8'("@"));
				repeat ($urandom_range(0, 4)) add_char(pick_body());
			end
			3: begin
				if ($urandom_range(0, 1) == 1) begin
					add_char("-");
					add_char(($urandom_range(0, 3) == 0) ? 8'(".") : pick_digit());
				end else begin
					add_char(pick_digit());
				end
				repeat ($urandom_range(0, 3))
					add_char(($urandom_range(0, 3) == 0) ? 8'(".") : pick_digit());
				if ($urandom_range(0, 1) == 1) begin
					add_char(($urandom_range(0, 1) == 1) ? 8'("e") : 8'("E"));
					case ($urandom_range(0, 2))
						0:       add_char("+");
						1:       add_char("-");
						default: add_char(pick_digit());
					endcase
					repeat ($urandom_range(0, 2)) add_char(pick_digit());
				end
			end
			4: begin
				word = ($urandom_range(0, 1) == 1) ? "-inf" : "-nan";
				for (int i = 0; i < 4; i++) add_char(word[i]);
				repeat ($urandom_range(0, 2)) add_char(pick_body());
			end
			5: begin
				// Cut the lookahead short and break it with some other byte.
				word = ($urandom_range(0, 1) == 1) ? "-inf" : "-nan";
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) add_char(word[i]);
				case ($urandom_range(0, 3))
					0:       add_char(pick_body());
					1:       add_char(pick_punct());
					2:       add_char(">");
					default: add_char(pick_blank());
				endcase
			end
			6: begin
				add_char("-");
				add_char(">");
			end
			7, 8:    add_char(pick_punct());
			9:       add_char(pick_blank());
			10:      add_char(8'($urandom_range(0, 255)));
			default: add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		endcase
	endfunction

	function automatic void build_line();
		line_q.delete();
		repeat ($urandom_range(1, 6)) begin
			add_fragment();
			if ($urandom_range(0, 1) == 1)
				add_char(" ");
		end
		if ($urandom_range(0, 1) == 1)
			line_q[line_q.size() - 1].last = 1'b1;
		else
			add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endfunction

	initial begin
		int  random_count;
		bit  paused;
		random_count = 0;
		paused       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines.
		send_text("-i(", 1'b1);          // broken lookahead, four tokens at once
		send_text("-nan -", 1'b1);       // full -nan, then a minus ending the line
		send_text("->", 1'b0);           // arrow, line ended by a bare item
		send_byte(8'hA5, 1'b0, 1'b0);    // bare item, nothing comes out
		send_byte(8'hFF, 1'b1, 1'b0);    // high byte and NUL are unknown tokens
		send_byte(8'h00, 1'b1, 1'b1);
		send_text("%", 1'b1);            // sigil alone, empty register name
		send_text("()[]{},:?=", 1'b1);   // every punctuation kind
		drain();

		// Random lines; some run with no idling on either side.
		while (random_count < RANDOM_ITEMS) begin
			if (!paused && random_count >= RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			calm = ($urandom_range(0, 3) == 0);
			build_line();
			foreach (line_q[i]) begin
				send_byte(line_q[i].ch, line_q[i].has, line_q[i].last);
				random_count++;
			end
		end
		calm = 1'b0;

		drain();
		// Allow for tokens still in the output pipeline.
		repeat (8) @(posedge clk);
		$display("Covered %0d input transfers over %0d lines, with a full drain midway.",
			bytes_sent, lines_sent);
		$display("Checked %0d tokens covering %0d of 17 token kinds.", tokens_checked,
			$countones(kinds_seen));
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/irlt_pkg.sv
hw/rtl/irlt_front.sv
hw/rtl/irlt_queue.sv
hw/rtl/irlt_back.sv
hw/rtl/ir_line_tokenizer.sv
dv/irlt_token_checker.sv
dv/tb.sv
